// ----- sv/ppst_pkg.sv -----
// Shared types and constants for the per-peer sequence tracker.
`timescale 1ns / 1ps

package ppst_pkg;

    localparam int SEQ_W      = 8;
    localparam int SRC_W      = 16;
    localparam int MAP_BITS   = 256;
    // Widest slot index; 8 bits cover a peer table of up to 256 slots.
    localparam int SLOT_MAX_W = 8;

    localparam logic [1:0] CMD_QUERY  = 2'd0;
    localparam logic [1:0] CMD_MARK   = 2'd1;
    localparam logic [1:0] CMD_UPDATE = 2'd2;
    localparam logic [1:0] CMD_RESET  = 2'd3;

    localparam logic [SEQ_W-1:0] SEQ_HALF = 8'd128;
    localparam logic [SEQ_W-1:0] SEQ_ONE  = 8'd1;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [SRC_W-1:0] source;
        logic [SEQ_W-1:0] seq;
    } ppst_in_t;

    typedef struct packed {
        logic             duplicate;
        logic             out_of_order;
        logic [SEQ_W-1:0] expected_seq;
        logic             status;
    } ppst_out_t;

    // Classified item handed from the front to the back.
    typedef struct packed {
        logic [1:0]            cmd;
        logic [SEQ_W-1:0]      seq;
        logic                  slot_ok;
        logic [SLOT_MAX_W-1:0] slot;
        logic                  status;
    } ppst_task_t;

    // One memory row: expected number and received map of one slot.
    typedef struct packed {
        logic [SEQ_W-1:0]    expected;
        logic [MAP_BITS-1:0] bits;
    } ppst_row_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CMP,
        F_PUSH
    } front_state_t;

    typedef enum logic {
        B_IDLE,
        B_READ
    } back_state_t;

endpackage

// ----- sv/ppst_queue.sv -----
// Two-entry queue of classified items between front and back.
`timescale 1ns / 1ps

module ppst_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  ppst_pkg::ppst_task_t wr_task,
    output logic                full,
    input  logic                pop,
    output ppst_pkg::ppst_task_t rd_task,
    output logic                empty
);
    import ppst_pkg::*;

    ppst_task_t  slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rd_task = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_task;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ----- sv/ppst_front.sv -----
// Front: accepts items, matches the source against the peer table, allocates slots.
`timescale 1ns / 1ps

module ppst_front #(
    parameter int PEERS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ppst_pkg::ppst_in_t   s_data,
    output logic                 push,
    output ppst_pkg::ppst_task_t task_out,
    input  logic                 q_full
);
    import ppst_pkg::*;

    localparam int SLOT_W = (PEERS > 1) ? $clog2(PEERS) : 1;
    localparam int CNT_W  = $clog2(PEERS + 1);

    front_state_t       state_reg, state_next;
    ppst_in_t           in_reg;
    logic [SRC_W-1:0]   src_reg [PEERS];
    logic [CNT_W-1:0]   count_reg;
    logic [PEERS-1:0]   hit_vec_reg, hit_vec_next;
    logic [SLOT_W-1:0]  slot_enc;
    logic               hit_any;
    logic               wants_slot;
    logic               table_full;
    logic               alloc;

    // Slots fill from zero upward and are never released, so the first
    // count_reg slots are exactly the valid ones.
    always_comb begin
        for (int p = 0; p < PEERS; p++) begin
            hit_vec_next[p] = (CNT_W'(p) < count_reg) && (src_reg[p] == in_reg.source);
        end
    end

    // Source ids are unique among valid slots, so at most one bit is set.
    always_comb begin
        slot_enc = '0;
        for (int p = 0; p < PEERS; p++) begin
            if (hit_vec_reg[p]) begin
                slot_enc = slot_enc | SLOT_W'(p);
            end
        end
    end

    assign hit_any    = |hit_vec_reg;
    assign wants_slot = (in_reg.cmd == CMD_MARK) || (in_reg.cmd == CMD_UPDATE);
    assign table_full = (count_reg == CNT_W'(PEERS));
    assign alloc      = !hit_any && wants_slot && !table_full;

    always_comb begin
        task_out.cmd     = in_reg.cmd;
        task_out.seq     = in_reg.seq;
        task_out.slot_ok = hit_any || alloc;
        task_out.slot    = hit_any ? SLOT_MAX_W'(slot_enc) : SLOT_MAX_W'(count_reg);
        task_out.status  = !hit_any && wants_slot && table_full;
    end

    always_comb begin
        case (state_reg)
            F_IDLE:  state_next = s_valid ? F_CMP : F_IDLE;
            F_CMP:   state_next = F_PUSH;
            F_PUSH: begin
                if (q_full) begin
                    state_next = F_PUSH;
                end else begin
                    state_next = s_valid ? F_CMP : F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb begin
        case (state_reg)
            F_IDLE: begin
                s_ready = 1'b1;
                push    = 1'b0;
            end
            F_PUSH: begin
                s_ready = !q_full;
                push    = !q_full;
            end
            default: begin
                s_ready = 1'b0;
                push    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        hit_vec_reg <= hit_vec_next;
        if (push && alloc) begin
            src_reg[count_reg[SLOT_W-1:0]] <= in_reg.source;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (push && alloc) begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(PEERS))
        else $error("peer count above table size");

    a_unique_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == F_PUSH |-> $onehot0(hit_vec_reg))
        else $error("source matched more than one slot");

    a_alloc_count: assert property (@(posedge aclk) disable iff (!aresetn)
        push && alloc |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("allocation did not advance peer count");
`endif

endmodule

// ----- sv/ppst_back.sv -----
// Back: read-modify-write of the per-slot row memory and result register.
`timescale 1ns / 1ps

module ppst_back #(
    parameter int PEERS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ppst_pkg::ppst_task_t task_in,
    input  logic                 q_empty,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ppst_pkg::ppst_out_t  m_data
);
    import ppst_pkg::*;

    localparam int SLOT_W = (PEERS > 1) ? $clog2(PEERS) : 1;

    back_state_t      state_reg, state_next;
    ppst_task_t       task_reg;
    ppst_row_t        mem [PEERS];
    ppst_row_t        rd_row_reg;
    ppst_row_t        cur_row;
    ppst_row_t        new_row;
    logic [PEERS-1:0] row_valid_reg;
    logic [SLOT_W-1:0] slot;
    logic             row_ok;
    logic             out_free;
    logic             commit;
    logic             wr_en;
    logic             clear_all;
    logic [SEQ_W-1:0] diff;
    logic             m_valid_reg;
    ppst_out_t        m_data_reg;
    ppst_out_t        result;

    assign slot     = task_reg.slot[SLOT_W-1:0];
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // A row whose valid bit is clear reads as an empty map with expected 0.
    assign row_ok  = task_reg.slot_ok && row_valid_reg[slot];
    assign cur_row = row_ok ? rd_row_reg : '0;
    assign diff    = task_reg.seq - cur_row.expected;

    always_comb begin
        new_row = cur_row;
        if (task_reg.cmd == CMD_MARK) begin
            new_row.bits[task_reg.seq] = 1'b1;
        end else begin
            new_row.expected = task_reg.seq + SEQ_ONE;
        end
    end

    always_comb begin
        result.duplicate    = cur_row.bits[task_reg.seq];
        result.out_of_order = (diff != '0) && (diff != SEQ_HALF);
        result.expected_seq = cur_row.expected;
        result.status       = task_reg.status;
    end

    always_comb begin
        case (state_reg)
            B_IDLE:  state_next = q_empty ? B_IDLE : B_READ;
            B_READ:  state_next = out_free ? B_IDLE : B_READ;
            default: state_next = B_IDLE;
        endcase
    end

    always_comb begin
        case (state_reg)
            B_IDLE: begin
                pop    = !q_empty;
                commit = 1'b0;
            end
            B_READ: begin
                pop    = 1'b0;
                commit = out_free;
            end
            default: begin
                pop    = 1'b0;
                commit = 1'b0;
            end
        endcase
    end

    assign wr_en = commit && task_reg.slot_ok &&
                   ((task_reg.cmd == CMD_MARK) || (task_reg.cmd == CMD_UPDATE));
    assign clear_all = commit && (task_reg.cmd == CMD_RESET);

    always_ff @(posedge aclk) begin
        if (pop) begin
            task_reg   <= task_in;
            rd_row_reg <= mem[task_in.slot[SLOT_W-1:0]];
        end
        if (wr_en) begin
            mem[slot] <= new_row;
        end
        if (commit) begin
            m_data_reg <= result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            row_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (clear_all) begin
                row_valid_reg <= '0;
            end else if (wr_en) begin
                row_valid_reg[slot] <= 1'b1;
            end
            if (commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTH
    a_write_real_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> state_reg == B_READ && task_reg.slot_ok && !task_reg.status)
        else $error("row write without an owned slot");

    a_clear_rows: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_all |=> row_valid_reg == '0)
        else $error("reset command left a row valid");

    a_full_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        commit && task_reg.status |-> !wr_en && !task_reg.slot_ok)
        else $error("full-table item changed state");
`endif

endmodule

// ----- sv/per_peer_sequence_tracker.sv -----
// Top level of the per-peer sequence tracker: front, queue and back.
`timescale 1ns / 1ps

//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-----------------------------------------
//  s_      | in        | s_valid / s_ready  | s_data: cmd, source, seq
//  m_      | out       | m_valid / m_ready  | m_data: duplicate, out_of_order,
//          |           |                    |         expected_seq, status
//
//  Steps: the front does the parallel source compare, then slot encode/allocate;
//  the back does the row read, then the row write and result load. The front
//  accepts a new item in the same cycle as it pushes the previous one to the queue.
//  Reset: aresetn is synchronous, active low; it empties the peer table, the
//  queue and the row valid bits. No clearing pass: rows count as empty until written.
//  Stalls: a busy result register holds the back; the two-entry queue keeps the front going.

module per_peer_sequence_tracker #(
    parameter int PEERS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ppst_pkg::ppst_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ppst_pkg::ppst_out_t m_data
);
    import ppst_pkg::*;

    // Classified items flow front -> queue -> back.
    ppst_task_t front_task;
    ppst_task_t back_task;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;

    // Front owns the peer table: it resolves hits and allocates new slots in
    // transfer order, so the back never needs to look up source ids.
    ppst_front #(
        .PEERS(PEERS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .push    (q_push),
        .task_out(front_task),
        .q_full  (q_full)
    );

    ppst_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_task (front_task),
        .full    (q_full),
        .pop     (q_pop),
        .rd_task (back_task),
        .empty   (q_empty)
    );

    // Back owns the per-slot rows (expected number plus 256-bit map) and the
    // result register; a reset command drops every row valid bit at once.
    ppst_back #(
        .PEERS(PEERS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .task_in (back_task),
        .q_empty (q_empty),
        .pop     (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ----- bench/per_peer_sequence_tracker_test.sv -----
// Self-checking testbench for the per-peer sequence tracker.
`timescale 1ns / 1ps

module per_peer_sequence_tracker_test;
    import ppst_pkg::*;

    localparam int PEERS        = 16;
    localparam int IDLE_LIMIT   = 5000;   // cycles without any transfer before giving up
    localparam int HOLD_CYCLES  = 200;    // long receiver hold-off
    localparam int DRAIN_CYCLES = 20;     // well past the latency of the block
    localparam int PHASE_ITEMS  = 270;    // three phases, about 800 random items in all

    // Shadow of the peer table; predicts one report per accepted transfer and
    // holds the reports still owed by the block.
    class peer_seq_scoreboard;
        bit               slot_used [PEERS];
        logic [SRC_W-1:0] slot_src  [PEERS];
        logic [SEQ_W-1:0] slot_next [PEERS];
        logic [MAP_BITS-1:0] slot_seen [PEERS];
        ppst_out_t        owed_reports [$];
        int unsigned      errors;

        function new();
            for (int p = 0; p < PEERS; p++) begin
                slot_used[p] = 1'b0;
                slot_src[p]  = '0;
                slot_next[p] = '0;
                slot_seen[p] = '0;
            end
            errors = 0;
        endfunction

        // Lowest valid slot holding this source, PEERS when unknown.
        function int find_slot(logic [SRC_W-1:0] src);
            for (int p = 0; p < PEERS; p++) begin
                if (slot_used[p] && slot_src[p] == src) return p;
            end
            return PEERS;
        endfunction

        function int free_slot();
            for (int p = 0; p < PEERS; p++) begin
                if (!slot_used[p]) return p;
            end
            return PEERS;
        endfunction

        function logic [SEQ_W-1:0] expected_of(logic [SRC_W-1:0] src);
            int slot;
            slot = find_slot(src);
            return (slot < PEERS) ? slot_next[slot] : '0;
        endfunction

        function int pending();
            return owed_reports.size();
        endfunction

        function void note_transfer(ppst_in_t item);
            int               slot;
            ppst_out_t        rep;
            logic [SEQ_W-1:0] diff;
            slot = find_slot(item.source);
            rep  = '0;
            // Report the state before the command takes effect.
            if (slot < PEERS) begin
                rep.expected_seq = slot_next[slot];
                rep.duplicate    = slot_seen[slot][item.seq];
            end
            diff = item.seq - rep.expected_seq;
            rep.out_of_order = (diff != '0) && (diff != SEQ_HALF);
            if (item.cmd == CMD_MARK || item.cmd == CMD_UPDATE) begin
                if (slot == PEERS) begin
                    slot = free_slot();
                    if (slot < PEERS) begin
                        slot_used[slot] = 1'b1;
                        slot_src[slot]  = item.source;
                        slot_next[slot] = '0;
                        slot_seen[slot] = '0;
                    end
                end
                if (slot == PEERS) begin
                    rep.status = 1'b1;
                end else if (item.cmd == CMD_MARK) begin
                    slot_seen[slot][item.seq] = 1'b1;
                end else begin
                    slot_next[slot] = item.seq + SEQ_ONE;
                end
            end else if (item.cmd == CMD_RESET) begin
                // Clear maps and expected numbers, keep the peers.
                for (int p = 0; p < PEERS; p++) begin
                    slot_next[p] = '0;
                    slot_seen[p] = '0;
                end
            end
            owed_reports.push_back(rep);
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_report(ppst_out_t got);
            ppst_out_t want;
            if (owed_reports.size() == 0) begin
                errors++;
                $display("%0t: unexpected report: expected none, actual %h", $time, got);
                return;
            end
            want = owed_reports.pop_front();
            check_field("duplicate",    want.duplicate,    got.duplicate);
            check_field("out_of_order", want.out_of_order, got.out_of_order);
            check_field("expected_seq", want.expected_seq, got.expected_seq);
            check_field("status",       want.status,       got.status);
        endfunction
    endclass

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    ppst_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    ppst_out_t m_data;

    peer_seq_scoreboard sb;
    int                 src_idle_pct = 0;
    int                 rcv_idle_pct = 0;
    bit                 hold_pending = 1'b0;
    int unsigned        items_sent   = 0;
    logic [SRC_W-1:0]   known_src [PEERS];

    per_peer_sequence_tracker #(
        .PEERS (PEERS)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver: take reports with random back-pressure; on request hold off
    // for a long stretch so the block fills up and stalls its input.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_pending) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_pending = 1'b0;
            end else begin
                m_ready <= (rcv_idle_pct == 0) || ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    // Check every report transfer against the oldest prediction.
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) sb.check_report(m_data);
        end
    end

    // Watchdog: give up when nothing moves on either channel for too long.
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
            if (quiet >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic ppst_in_t make_item(logic [1:0] cmd, logic [SRC_W-1:0] src,
                                           logic [SEQ_W-1:0] seq);
        ppst_in_t item;
        item.cmd    = cmd;
        item.source = src;
        item.seq    = seq;
        return item;
    endfunction

    // Offer one item, hold it until the transfer, then note it for prediction.
    // Call at a rising edge; returns at the edge of the transfer.
    task automatic send_item(input ppst_in_t item);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_transfer(item);
        items_sent++;
    endtask

    task automatic send(logic [1:0] cmd, logic [SRC_W-1:0] src, logic [SEQ_W-1:0] seq);
        send_item(make_item(cmd, src, seq));
    endtask

    // Pause the sender until every predicted report has come back.
    task automatic drain_reports();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // Mostly in-order traffic for the known peers, plus duplicates, stray
    // numbers, resets and items from unknown sources.
    task automatic run_phase(int n);
        int unsigned      start;
        int unsigned      pick;
        logic [SRC_W-1:0] src;
        logic [SEQ_W-1:0] nxt;
        logic [SEQ_W-1:0] seq;
        start = items_sent;
        while (items_sent - start < n) begin
            pick = $urandom_range(99);
            src  = known_src[$urandom_range(PEERS - 1)];
            nxt  = sb.expected_of(src);
            if (pick < 40) begin
                // Packet arrives in order (now and then exactly half way off):
                // mark it, then advance the expected number.
                seq = ($urandom_range(7) == 0) ? nxt + SEQ_HALF : nxt;
                send(CMD_MARK, src, seq);
                send(CMD_UPDATE, src, seq);
            end else if (pick < 50) begin
                send(CMD_MARK, src, nxt - SEQ_ONE);
            end else if (pick < 62) begin
                send(CMD_QUERY, src, $urandom_range(1) ? nxt : SEQ_W'($urandom));
            end else if (pick < 74) begin
                send(CMD_MARK, src, SEQ_W'($urandom));
            end else if (pick < 84) begin
                send(CMD_UPDATE, src, SEQ_W'($urandom));
            end else if (pick < 86) begin
                send(CMD_RESET, src, SEQ_W'($urandom));
            end else begin
                send(2'($urandom_range(2)), SRC_W'($urandom), SEQ_W'($urandom));
            end
        end
    endtask

    initial begin
        sb = new();
        // Two fixed ids at the extremes, the rest with distinct top nibbles.
        known_src[0] = '0;
        known_src[1] = '1;
        for (int k = 2; k < PEERS; k++) known_src[k] = {4'(k - 1), 12'($urandom)};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: unknown source, duplicates, wrap of the expected number,
        // the half-way distance, the reset command, then a full table.
        send(CMD_QUERY,  known_src[0], 8'd0);
        send(CMD_MARK,   known_src[0], 8'd0);
        send(CMD_MARK,   known_src[0], 8'd0);
        send(CMD_UPDATE, known_src[0], 8'd255);
        send(CMD_QUERY,  known_src[0], SEQ_HALF);
        send(CMD_MARK,   known_src[1], 8'd255);
        send(CMD_UPDATE, known_src[1], 8'd127);
        send(CMD_QUERY,  known_src[1], 8'd0);
        send(CMD_QUERY,  known_src[1], SEQ_HALF);
        send(CMD_MARK,   known_src[1], 8'd255);
        send(CMD_RESET,  known_src[1], 8'd255);
        send(CMD_QUERY,  known_src[0], 8'd0);
        for (int k = 2; k < PEERS; k++) send(CMD_MARK, known_src[k], SEQ_W'($urandom));
        send(CMD_MARK,   16'h0F0F, 8'd7);
        send(CMD_UPDATE, 16'h0F0F, 8'd8);
        send(CMD_QUERY,  16'h0F0F, 8'd9);
        drain_reports();

        // Random: sender idles 30%, receiver 55%, with one long hold-off.
        src_idle_pct = 30;
        rcv_idle_pct = 55;
        hold_pending = 1'b1;
        run_phase(PHASE_ITEMS);
        drain_reports();

        src_idle_pct = 55;
        rcv_idle_pct = 30;
        run_phase(PHASE_ITEMS);
        drain_reports();

        src_idle_pct = 0;
        rcv_idle_pct = 0;
        run_phase(PHASE_ITEMS);
        drain_reports();

        // Linger to catch any stray report.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0t: %0d mismatches, %0d reports missing", $time, sb.errors,
                     sb.pending());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
